FILE: design/vbqe_pkg.sv
package vbqe_pkg;

  // Field widths
  localparam int COORD_W   = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CORNER_W  = 13;
  localparam int DIR_W     = 3;
  localparam int TOTAL_W   = 15;
  localparam int STEP_W    = 5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH  = 2'd2;

  // Request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EMIT  = 1'b1;

  // Face directions
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd0;
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd1;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd2;
  localparam logic [DIR_W-1:0] DIR_PY = 3'd3;
  localparam logic [DIR_W-1:0] DIR_NX = 3'd4;
  localparam logic [DIR_W-1:0] DIR_PX = 3'd5;

  // Occupancy read / capture targets
  localparam logic [2:0] TGT_NONE   = 3'd0;
  localparam logic [2:0] TGT_CENTER = 3'd1;
  localparam logic [2:0] TGT_NZ     = 3'd2;
  localparam logic [2:0] TGT_PZ     = 3'd3;
  localparam logic [2:0] TGT_NY     = 3'd4;
  localparam logic [2:0] TGT_PY     = 3'd5;
  localparam logic [2:0] TGT_NX     = 3'd6;
  localparam logic [2:0] TGT_PX     = 3'd7;

  // Index arithmetic steps
  localparam logic [1:0] CALC_NONE = 2'd0;
  localparam logic [1:0] CALC_T    = 2'd1;
  localparam logic [1:0] CALC_S    = 2'd2;
  localparam logic [1:0] CALC_SUM  = 2'd3;

  // Result emission
  localparam logic [1:0] EM_NONE  = 2'd0;
  localparam logic [1:0] EM_FACE  = 2'd1;
  localparam logic [1:0] EM_BLANK = 2'd2;

  // Jump conditions
  localparam logic [1:0] JC_NEXT   = 2'd0;
  localparam logic [1:0] JC_ALWAYS = 2'd1;
  localparam logic [1:0] JC_WRITE  = 2'd2;
  localparam logic [1:0] JC_NOQUAD = 2'd3;

  // Program steps
  localparam logic [STEP_W-1:0] ST_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] ST_DISPATCH = 5'd1;
  localparam logic [STEP_W-1:0] ST_RD_NZ    = 5'd2;
  localparam logic [STEP_W-1:0] ST_RD_PZ    = 5'd3;
  localparam logic [STEP_W-1:0] ST_RD_NY    = 5'd4;
  localparam logic [STEP_W-1:0] ST_RD_PY    = 5'd5;
  localparam logic [STEP_W-1:0] ST_RD_NX    = 5'd6;
  localparam logic [STEP_W-1:0] ST_RD_PX    = 5'd7;
  localparam logic [STEP_W-1:0] ST_CAP_PX   = 5'd8;
  localparam logic [STEP_W-1:0] ST_CHECK    = 5'd9;
  localparam logic [STEP_W-1:0] ST_FACE0    = 5'd10;
  localparam logic [STEP_W-1:0] ST_FACE5    = 5'd15;
  localparam logic [STEP_W-1:0] ST_BLANK    = 5'd16;

  typedef struct packed {
    logic              take;
    logic              wr;
    logic [2:0]        rd;
    logic [2:0]        cap;
    logic [1:0]        calc;
    logic [1:0]        emit;
    logic [DIR_W-1:0]  face;
    logic [1:0]        jc;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic is_write;
    logic no_quad;
    logic hold;
  } stat_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t u;
    u = '0;
    case (step) inside
      ST_IDLE: begin
        u.take = 1'b1;
      end
      ST_DISPATCH: begin
        u.wr     = 1'b1;
        u.rd     = TGT_CENTER;
        u.calc   = CALC_T;
        u.jc     = JC_WRITE;
        u.target = ST_IDLE;
      end
      ST_RD_NZ: begin
        u.rd   = TGT_NZ;
        u.cap  = TGT_CENTER;
        u.calc = CALC_S;
      end
      ST_RD_PZ: begin
        u.rd   = TGT_PZ;
        u.cap  = TGT_NZ;
        u.calc = CALC_SUM;
      end
      ST_RD_NY: begin
        u.rd  = TGT_NY;
        u.cap = TGT_PZ;
      end
      ST_RD_PY: begin
        u.rd  = TGT_PY;
        u.cap = TGT_NY;
      end
      ST_RD_NX: begin
        u.rd  = TGT_NX;
        u.cap = TGT_PY;
      end
      ST_RD_PX: begin
        u.rd  = TGT_PX;
        u.cap = TGT_NX;
      end
      ST_CAP_PX: begin
        u.cap = TGT_PX;
      end
      ST_CHECK: begin
        u.jc     = JC_NOQUAD;
        u.target = ST_BLANK;
      end
      [ST_FACE0:ST_FACE5]: begin
        u.emit = EM_FACE;
        u.face = DIR_W'(step - ST_FACE0);
        if (step == ST_FACE5) begin
          u.jc     = JC_ALWAYS;
          u.target = ST_IDLE;
        end
      end
      ST_BLANK: begin
        u.emit   = EM_BLANK;
        u.jc     = JC_ALWAYS;
        u.target = ST_IDLE;
      end
      default: begin
        u.jc     = JC_ALWAYS;
        u.target = ST_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

FILE: design/vbqe_if.sv
// Request channel: cell write or emit
interface vbqe_cmd_if import vbqe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic [COORD_W-1:0] cell_z;
  logic               occupied;

  modport source (output valid, func, cell_x, cell_y, cell_z, occupied, input ready);
  modport sink (input valid, func, cell_x, cell_y, cell_z, occupied, output ready);
endinterface

// Result channel: one quad (or one blank) per result
interface vbqe_quad_if import vbqe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CORNER_W-1:0] corner_a;
  logic [CORNER_W-1:0] corner_b;
  logic [CORNER_W-1:0] corner_c;
  logic [CORNER_W-1:0] corner_d;
  logic [DIR_W-1:0]    face_dir;
  logic                face_valid;
  logic                last_face;
  logic [TOTAL_W-1:0]  total_faces;

  modport source (output valid, corner_a, corner_b, corner_c, corner_d, face_dir,
                  face_valid, last_face, total_faces, input ready);
  modport sink (input valid, corner_a, corner_b, corner_c, corner_d, face_dir,
                face_valid, last_face, total_faces, output ready);
endinterface

FILE: design/vbqe_voxel_mem.sv
module vbqe_voxel_mem #(
  parameter int CELLS = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          rst,
  output logic          ready,
  input  logic [AW-1:0] addr,
  input  logic          wr_en,
  input  logic          wr_data,
  input  logic          rd_en,
  output logic          rd_data
);

  logic          mem [CELLS];
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Clearing pass after reset, one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(CELLS - 1)) clearing <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Single write port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[addr];
  end

  assign ready = !clearing;

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wr_en)
    else $error("cell write during clearing pass");

endmodule

FILE: design/vbqe_seq.sv
module vbqe_seq import vbqe_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  stat_t  stat,
  output ucode_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  assign ctrl = ucode_rom(step);

  // Step counter with conditional jumps
  always_comb begin
    step_next = step + 1'b1;
    if (stat.hold) begin
      step_next = step;
    end else if (ctrl.take) begin
      if (!stat.accept) step_next = step;
    end else begin
      case (ctrl.jc)
        JC_NEXT:   step_next = step + 1'b1;
        JC_ALWAYS: step_next = ctrl.target;
        JC_WRITE:  if (stat.is_write) step_next = ctrl.target;
        JC_NOQUAD: if (stat.no_quad) step_next = ctrl.target;
        default:   step_next = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) step <= ST_IDLE;
    else     step <= step_next;
  end

  a_wait_in_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.take && !stat.accept) |=> (step == ST_IDLE))
    else $error("sequencer left idle without a request");

  a_hold_on_emit: assert property (@(posedge clk) disable iff (rst)
    stat.hold |-> (ctrl.emit != EM_NONE))
    else $error("hold outside an emit step");

endmodule

FILE: design/vbqe_dpath.sv
module vbqe_dpath import vbqe_pkg::*; #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16,
  parameter int MAX_DEPTH  = 16,
  parameter int AW         = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  vbqe_cmd_if.sink             cmd,
  vbqe_quad_if.source          quad,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  ucode_t               ctrl,
  output stat_t                stat,
  input  logic                 mem_ready,
  output logic [AW-1:0]        mem_addr,
  output logic                 mem_wr_en,
  output logic                 mem_wr_data,
  output logic                 mem_rd_en,
  input  logic                 mem_rd_data
);

  localparam logic [6:0] MW = 7'(MAX_WIDTH);
  localparam logic [6:0] MH = 7'(MAX_HEIGHT);
  localparam logic [6:0] MD = 7'(MAX_DEPTH);

  logic [CFG_W-1:0]    grid_width;
  logic [CFG_W-1:0]    grid_height;
  logic [CFG_W-1:0]    grid_depth;
  logic [CFG_W-1:0]    w, h, d;
  logic [CFG_W:0]      w1, hp1;

  logic                func_r, occ_r;
  logic [COORD_W-1:0]  x_r, y_r, z_r;
  logic [COORD_W:0]    xc, yc, zc;
  logic [COORD_W:0]    nx, ny, nz;

  logic                in_range, write_ok, rd_ok;
  logic [5:0]          edge_hit;
  logic [5:0]          side;
  logic                center_occ;
  logic [DIR_W-1:0]    rd_face, cap_face;

  logic [CORNER_W-1:0] t, s, o, sw, os, osw;
  logic [CORNER_W-1:0] ca, cb, cc, cd;

  logic                side_hit, is_last, place, hold, go;
  logic                out_valid;
  logic [TOTAL_W-1:0]  total, total_inc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= '0;
      grid_height <= '0;
      grid_depth  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        REG_GRID_DEPTH:  grid_depth  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Grid size in use, limited to the store
  assign w   = ({2'b0, grid_width}  > MW) ? MW[CFG_W-1:0] : grid_width;
  assign h   = ({2'b0, grid_height} > MH) ? MH[CFG_W-1:0] : grid_height;
  assign d   = ({2'b0, grid_depth}  > MD) ? MD[CFG_W-1:0] : grid_depth;
  assign w1  = {1'b0, w} + 1'b1;
  assign hp1 = {1'b0, h} + 1'b1;

  // Request capture
  assign cmd.ready   = ctrl.take && mem_ready;
  assign stat.accept = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (stat.accept) begin
      func_r <= cmd.func;
      x_r    <= cmd.cell_x;
      y_r    <= cmd.cell_y;
      z_r    <= cmd.cell_z;
      occ_r  <= cmd.occupied;
    end
  end

  assign xc = {1'b0, x_r};
  assign yc = {1'b0, y_r};
  assign zc = {1'b0, z_r};

  assign in_range = (xc < w) && (yc < h) && (zc < d);
  assign write_ok = ({3'b0, x_r} < MW) && ({3'b0, y_r} < MH) && ({3'b0, z_r} < MD);

  // Grid boundary per side
  assign edge_hit[DIR_NZ] = (z_r == '0);
  assign edge_hit[DIR_PZ] = ((zc + 1'b1) == d);
  assign edge_hit[DIR_NY] = (y_r == '0);
  assign edge_hit[DIR_PY] = ((yc + 1'b1) == h);
  assign edge_hit[DIR_NX] = (x_r == '0);
  assign edge_hit[DIR_PX] = ((xc + 1'b1) == w);

  // Neighbor selection and cell address
  assign rd_face  = DIR_W'(ctrl.rd - TGT_NZ);
  assign cap_face = DIR_W'(ctrl.cap - TGT_NZ);

  always_comb begin
    nx    = xc;
    ny    = yc;
    nz    = zc;
    rd_ok = in_range && !edge_hit[rd_face];
    case (ctrl.rd)
      TGT_NONE:   rd_ok = 1'b0;
      TGT_CENTER: rd_ok = in_range;
      TGT_NZ:     nz = zc - 1'b1;
      TGT_PZ:     nz = zc + 1'b1;
      TGT_NY:     ny = yc - 1'b1;
      TGT_PY:     ny = yc + 1'b1;
      TGT_NX:     nx = xc - 1'b1;
      TGT_PX:     nx = xc + 1'b1;
      default:    rd_ok = 1'b0;
    endcase
  end

  assign mem_addr    = AW'(nx) + AW'(MAX_WIDTH) * (AW'(ny) + AW'(MAX_HEIGHT) * AW'(nz));
  assign mem_rd_en   = rd_ok;
  assign mem_wr_en   = ctrl.wr && stat.is_write && write_ok;
  assign mem_wr_data = occ_r;

  // Occupancy capture, one step after each read
  always_ff @(posedge clk) begin
    case (ctrl.cap)
      TGT_NONE:   ;
      TGT_CENTER: center_occ <= mem_rd_data;
      default:    side[cap_face] <= edge_hit[cap_face] || !mem_rd_data;
    endcase
  end

  assign stat.is_write = (func_r == FUNC_WRITE);
  assign stat.no_quad  = !in_range || !center_occ || (side == '0);

  // Vertex index arithmetic, at most one multiply level per step
  always_ff @(posedge clk) begin
    case (ctrl.calc)
      CALC_T: t <= CORNER_W'(y_r) + CORNER_W'(hp1) * CORNER_W'(z_r);
      CALC_S: begin
        s <= CORNER_W'(x_r) + CORNER_W'(w1) * t;
        o <= CORNER_W'(w1) * CORNER_W'(hp1);
      end
      CALC_SUM: begin
        sw  <= s + CORNER_W'(w1);
        os  <= o + s;
        osw <= o + s + CORNER_W'(w1);
      end
      default: ;
    endcase
  end

  // Quad corners in winding order
  always_comb begin
    case (ctrl.face)
      DIR_NZ:  begin ca = s;          cb = sw;         cc = sw + 1'b1;  cd = s + 1'b1;  end
      DIR_PZ:  begin ca = os;         cb = os + 1'b1;  cc = osw + 1'b1; cd = osw;       end
      DIR_NY:  begin ca = s;          cb = s + 1'b1;   cc = os + 1'b1;  cd = os;        end
      DIR_PY:  begin ca = sw;         cb = osw;        cc = osw + 1'b1; cd = sw + 1'b1; end
      DIR_NX:  begin ca = s;          cb = os;         cc = osw;        cd = sw;        end
      DIR_PX:  begin ca = s + 1'b1;   cb = sw + 1'b1;  cc = osw + 1'b1; cd = os + 1'b1; end
      default: begin ca = '0;         cb = '0;         cc = '0;         cd = '0;        end
    endcase
  end

  // Face present and last present face
  always_comb begin
    side_hit = 1'b0;
    is_last  = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (ctrl.face == DIR_W'(i)) side_hit = side[i];
      if ((DIR_W'(i) > ctrl.face) && side[i]) is_last = 1'b0;
    end
  end

  assign place     = ((ctrl.emit == EM_FACE) && side_hit) || (ctrl.emit == EM_BLANK);
  assign hold      = place && out_valid && !quad.ready;
  assign go        = place && !hold;
  assign stat.hold = hold;

  // Running face count, saturating
  assign total_inc = (total == TOTAL_MAX) ? total : total + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctrl.wr && stat.is_write) begin
      total <= '0;
    end else if (go && (ctrl.emit == EM_FACE)) begin
      total <= total_inc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (quad.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (ctrl.emit == EM_FACE) begin
        quad.corner_a    <= ca;
        quad.corner_b    <= cb;
        quad.corner_c    <= cc;
        quad.corner_d    <= cd;
        quad.face_dir    <= ctrl.face;
        quad.face_valid  <= 1'b1;
        quad.last_face   <= is_last;
        quad.total_faces <= total_inc;
      end else begin
        quad.corner_a    <= '0;
        quad.corner_b    <= '0;
        quad.corner_c    <= '0;
        quad.corner_d    <= '0;
        quad.face_dir    <= DIR_NZ;
        quad.face_valid  <= 1'b0;
        quad.last_face   <= 1'b1;
        quad.total_faces <= total;
      end
    end
  end

  assign quad.valid = out_valid;

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (go && (ctrl.emit == EM_FACE) && (total != TOTAL_MAX)) |=>
      (total == $past(total) + 1'b1))
    else $error("face count did not advance");

  a_blank_result: assert property (@(posedge clk) disable iff (rst)
    (go && (ctrl.emit == EM_BLANK)) |=>
      (quad.valid && !quad.face_valid && quad.last_face))
    else $error("blank result malformed");

endmodule

FILE: design/voxel_boundary_quad_emitter_core.sv
// Write request: after accept, a dispatch step writes the cell; no result.
// Emit request: dispatch and read steps make seven one-port occupancy reads
//   (center, six neighbors), then a check; six face slots follow, one per cycle
//   unless the result channel stalls; a blank result instead if there is no quad.
// Reset (synchronous, active high) clears configuration, count and sequencer, then
//   a clearing pass over MAX_WIDTH*MAX_HEIGHT*MAX_DEPTH cells keeps cmd.ready low.
module voxel_boundary_quad_emitter_core import vbqe_pkg::*; #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16,
  parameter int MAX_DEPTH  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  vbqe_cmd_if.sink             cmd,
  vbqe_quad_if.source          quad,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  ucode_t        ctrl;
  stat_t         stat;
  logic          mem_ready;
  logic [AW-1:0] mem_addr;
  logic          mem_wr_en;
  logic          mem_wr_data;
  logic          mem_rd_en;
  logic          mem_rd_data;

  vbqe_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  vbqe_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH),
    .AW         (AW)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .quad        (quad),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ctrl        (ctrl),
    .stat        (stat),
    .mem_ready   (mem_ready),
    .mem_addr    (mem_addr),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_data (mem_rd_data)
  );

  vbqe_voxel_mem #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ready   (mem_ready),
    .addr    (mem_addr),
    .wr_en   (mem_wr_en),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_data (mem_rd_data)
  );

endmodule
